>>> hw/rtl/pwu_pkg.sv
package pwu_pkg;

    localparam int MAX_LANDMARKS = 64;
    localparam int MAX_OBS       = 16;
    localparam int ANGLE_BITS    = 16;

    localparam int MARK_AW = $clog2(MAX_LANDMARKS);
    localparam int MARK_CW = $clog2(MAX_LANDMARKS + 1);
    localparam int OBS_AW  = $clog2(MAX_OBS);
    localparam int OBS_CW  = $clog2(MAX_OBS + 1);

    localparam int MUL_W  = 35;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [56:0] NO_LINK_DIST2 = 57'd655360000000000;
    localparam logic [59:0] TERM_CAP      = 60'd1099511627776;
    localparam logic [20:0] LOG2E_Q20     = 21'd1512775;

    localparam logic [22:0] RANGE_RST = 23'd12800;
    localparam logic [23:0] IVAR_RST  = 24'd364089;
    localparam logic [23:0] NORM_RST  = 24'd53880;

    typedef enum logic [2:0] {
        KIND_ADD_MARK  = 3'd0,
        KIND_ADD_OBS   = 3'd1,
        KIND_WEIGH     = 3'd2,
        KIND_CLR_OBS   = 3'd3,
        KIND_CLR_MARKS = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CFG_RANGE = 2'd0,
        CFG_IVX   = 2'd1,
        CFG_IVY   = 2'd2,
        CFG_NORM  = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_TRIG_SQ, S_TRIG_Z, S_HORN_M, S_HORN_A, S_HORN_F, S_TRIG_R,
        S_OBS_RD, S_ROT0, S_ROT1, S_ROT2, S_ROT3, S_ROT4,
        S_LM_RD, S_LM_D, S_LM_SQ, S_LM_CMP, S_LINK,
        S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_E8, S_E9,
        S_FIN, S_POW, S_POW_R, S_OUT
    } t_state;

    // Horner coefficients, Q30
    function automatic logic signed [32:0] horner_k(input logic use_pow, input logic [2:0] idx);
        logic signed [32:0] k;
        k = '0;
        if (use_pow) begin
            unique case (idx)
                3'd0: k = 33'sd744261118;
                3'd1: k = 33'sd257941252;
                3'd2: k = 33'sd59597084;
                3'd3: k = 33'sd10327388;
                3'd4: k = 33'sd1431684;
                default: k = 33'sd165399;
            endcase
        end else begin
            unique case (idx)
                3'd0: k = 33'sd105414357;
                3'd1: k = -33'sd693598668;
                3'd2: k = 33'sd1369108894;
                3'd3: k = -33'sd1286910778;
                default: k = 33'sd705627793;
            endcase
        end
        return k;
    endfunction

    // fold a 32-bit turn angle into plus or minus a quarter turn around zero
    function automatic logic signed [31:0] fold_angle(input logic [31:0] a);
        logic signed [33:0] s;
        s = 34'(signed'(a));
        if (s > 34'sd1073741824)
            s = 34'sd2147483648 - s;
        else if (s < -34'sd1073741824)
            s = -34'sd2147483648 - s;
        return s[31:0];
    endfunction

endpackage

>>> hw/rtl/particle_weight_update.sv
// channel | direction | request signals              | payload
// in      | input     | i_in_valid / o_in_ready      | kind, tags, x/y, heading
// out     | output    | o_out_valid / i_out_ready    | tag, mantissa, exponent, count
// cfg     | input     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Table loads and clears do not leave the idle state. A weigh request runs on one shared
// multiplier: sin/cos first, then per observation a rotation and a scan of the landmarks, in
// which one outside the window is skipped and one inside it has its squared distance compared;
// a linked observation adds its term, then the finish runs (shorter when the exponent saturates).
// in_ready is low meanwhile. Reset (synchronous) empties both tables and restores the register defaults.
// A result waits in the output registers until taken; the next request waits too.
module particle_weight_update
    import pwu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic [15:0]        i_landmark_tag,
    input  logic signed [23:0] i_x_pos,
    input  logic signed [23:0] i_y_pos,
    input  logic [15:0]        i_heading,
    input  logic [15:0]        i_particle_tag,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_out_particle_tag,
    output logic [15:0]        o_weight_mantissa,
    output logic signed [15:0] o_weight_exponent,
    output logic [4:0]         o_matched_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    t_state r_state, n_state;

    logic [22:0]        r_range;
    logic [23:0]        r_ivx, r_ivy;
    logic signed [23:0] r_norm;

    logic [MARK_CW-1:0] r_mark_count, n_mark_count;
    logic [OBS_CW-1:0]  r_seen_count, n_seen_count;
    logic [MARK_CW-1:0] r_k, n_k;
    logic [OBS_CW-1:0]  r_i, n_i;

    logic [47:0] mark_mem [MAX_LANDMARKS];
    logic [47:0] seen_mem [MAX_OBS];
    logic [47:0] r_mark_q, r_seen_q;

    // datapath registers
    logic signed [23:0] r_px, n_px, r_py, n_py;
    logic [15:0]        r_head, n_head, r_ptag, n_ptag;
    logic               r_cos, n_cos;
    logic signed [31:0] r_s, n_s, r_sn, n_sn, r_cs, n_cs;
    logic signed [32:0] r_p, n_p;
    logic [29:0]        r_mz, n_mz;
    logic [2:0]         r_hidx, n_hidx;
    logic               r_pow, n_pow;
    logic signed [59:0] r_acc, n_acc;
    logic signed [26:0] r_tx, n_tx, r_ty, n_ty;
    logic signed [27:0] r_dx, n_dx, r_dy, n_dy, r_bdx, n_bdx, r_bdy, n_bdy;
    logic [55:0]        r_dsq, n_dsq;
    logic [56:0]        r_best, n_best;
    logic               r_linked, n_linked;
    logic [15:0]        r_ql, n_ql;
    logic [59:0]        r_e, n_e;
    logic signed [47:0] r_total, n_total;
    logic [4:0]         r_matched, n_matched;
    logic [15:0]        r_mant, n_mant;
    logic signed [15:0] r_exp, n_exp;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    pwu_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    logic               in_acc;
    logic [31:0]        ang;
    logic signed [23:0] mk_x, mk_y, ob_x, ob_y;
    logic signed [24:0] wdx, wdy;
    logic [24:0]        awdx, awdy;
    logic               keep;
    logic signed [PROD_W-1:0] tsum, tshift;
    logic [56:0]        dsum;
    logic [59:0]        esum;
    logic signed [31:0] exw;
    logic signed [PROD_W-1:0] pres;
    logic [PROD_W-1:0]  mres;
    logic               last_k, last_i;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;

    assign ang  = {r_head[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    assign mk_x = r_mark_q[47:24];
    assign mk_y = r_mark_q[23:0];
    assign ob_x = r_seen_q[47:24];
    assign ob_y = r_seen_q[23:0];
    assign wdx  = 25'(r_px) - 25'(mk_x);
    assign wdy  = 25'(r_py) - 25'(mk_y);
    assign awdx = wdx[24] ? 25'(-wdx) : 25'(wdx);
    assign awdy = wdy[24] ? 25'(-wdy) : 25'(wdy);
    assign keep = (awdx < {2'b00, r_range}) && (awdy < {2'b00, r_range});
    assign last_k = (r_k + 1'b1 == r_mark_count);
    assign last_i = (r_i + 1'b1 == r_seen_count);

    always_comb begin
        n_state = r_state;
        n_mark_count = r_mark_count; n_seen_count = r_seen_count;
        n_k = r_k; n_i = r_i;
        n_px = r_px; n_py = r_py; n_head = r_head; n_ptag = r_ptag;
        n_cos = r_cos; n_s = r_s; n_sn = r_sn; n_cs = r_cs;
        n_p = r_p; n_mz = r_mz; n_hidx = r_hidx; n_pow = r_pow;
        n_acc = r_acc; n_tx = r_tx; n_ty = r_ty;
        n_dx = r_dx; n_dy = r_dy; n_bdx = r_bdx; n_bdy = r_bdy;
        n_dsq = r_dsq; n_best = r_best; n_linked = r_linked;
        n_ql = r_ql; n_e = r_e; n_total = r_total; n_matched = r_matched;
        n_mant = r_mant; n_exp = r_exp;
        mul_a = '0; mul_b = '0;
        tsum = '0; tshift = '0; dsum = '0; esum = '0; exw = '0; pres = '0; mres = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority case (i_kind)
                        KIND_ADD_MARK: begin
                            if (r_mark_count < MARK_CW'(MAX_LANDMARKS))
                                n_mark_count = r_mark_count + 1'b1;
                        end
                        KIND_ADD_OBS: begin
                            if (r_seen_count < OBS_CW'(MAX_OBS))
                                n_seen_count = r_seen_count + 1'b1;
                        end
                        KIND_WEIGH: begin
                            n_px = i_x_pos; n_py = i_y_pos;
                            n_head = i_heading; n_ptag = i_particle_tag;
                            n_cos = 1'b0;
                            n_s = fold_angle({i_heading[ANGLE_BITS-1:0],
                                              {(32-ANGLE_BITS){1'b0}}});
                            n_total = '0; n_matched = '0; n_i = '0;
                            n_state = S_TRIG_SQ;
                        end
                        KIND_CLR_OBS:   n_seen_count = '0;
                        KIND_CLR_MARKS: n_mark_count = '0;
                        default: ;
                    endcase
                end
            end
            S_TRIG_SQ: begin
                mul_a = MUL_W'(r_s); mul_b = MUL_W'(r_s);
                n_state = S_TRIG_Z;
            end
            S_TRIG_Z: begin
                n_mz = 30'(prod >>> 34);
                n_pow = 1'b0;
                n_p = horner_k(1'b0, 3'd4);
                n_hidx = 3'd3;
                n_state = S_HORN_M;
            end
            S_HORN_M: begin
                mul_a = MUL_W'(r_p); mul_b = MUL_W'({1'b0, r_mz});
                n_state = S_HORN_A;
            end
            S_HORN_A: begin
                tshift = prod >>> 30;
                n_p = horner_k(r_pow, r_hidx) + tshift[32:0];
                if (r_hidx == 3'd0) begin
                    n_state = S_HORN_F;
                end else begin
                    n_hidx = r_hidx - 1'b1;
                    n_state = S_HORN_M;
                end
            end
            S_HORN_F: begin
                mul_a = MUL_W'(r_p);
                mul_b = r_pow ? MUL_W'({1'b0, r_mz}) : MUL_W'(r_s);
                n_state = r_pow ? S_POW_R : S_TRIG_R;
            end
            S_TRIG_R: begin
                pres = prod >>> 26;
                if (pres > PROD_W'(1073741824))
                    pres = PROD_W'(1073741824);
                else if (pres < -PROD_W'(1073741824))
                    pres = -PROD_W'(1073741824);
                if (!r_cos) begin
                    n_sn = pres[31:0];
                    n_cos = 1'b1;
                    n_s = fold_angle(ang + 32'h4000_0000);
                    n_state = S_TRIG_SQ;
                end else begin
                    n_cs = pres[31:0];
                    n_state = (r_seen_count == '0) ? S_FIN : S_OBS_RD;
                end
            end
            S_OBS_RD: n_state = S_ROT0;
            S_ROT0: begin
                mul_a = MUL_W'(r_cs); mul_b = MUL_W'(ob_x);
                n_state = S_ROT1;
            end
            S_ROT1: begin
                n_acc = prod[59:0];
                mul_a = MUL_W'(r_sn); mul_b = MUL_W'(ob_y);
                n_state = S_ROT2;
            end
            S_ROT2: begin
                tsum = (PROD_W'(r_acc) - prod + PROD_W'(536870912)) >>> 30;
                n_tx = 27'(tsum) + 27'(r_px);
                mul_a = MUL_W'(r_sn); mul_b = MUL_W'(ob_x);
                n_state = S_ROT3;
            end
            S_ROT3: begin
                n_acc = prod[59:0];
                mul_a = MUL_W'(r_cs); mul_b = MUL_W'(ob_y);
                n_state = S_ROT4;
            end
            S_ROT4: begin
                tsum = (PROD_W'(r_acc) + prod + PROD_W'(536870912)) >>> 30;
                n_ty = 27'(tsum) + 27'(r_py);
                n_best = NO_LINK_DIST2;
                n_linked = 1'b0;
                n_k = '0;
                n_state = (r_mark_count == '0) ? S_LINK : S_LM_RD;
            end
            S_LM_RD: n_state = S_LM_D;
            S_LM_D: begin
                n_dx = 28'(r_tx) - 28'(mk_x);
                n_dy = 28'(r_ty) - 28'(mk_y);
                mul_a = MUL_W'(28'(r_tx) - 28'(mk_x));
                mul_b = MUL_W'(28'(r_tx) - 28'(mk_x));
                if (keep) begin
                    n_state = S_LM_SQ;
                end else if (last_k) begin
                    n_state = S_LINK;
                end else begin
                    n_k = r_k + 1'b1;
                    n_state = S_LM_RD;
                end
            end
            S_LM_SQ: begin
                n_dsq = prod[55:0];
                mul_a = MUL_W'(r_dy); mul_b = MUL_W'(r_dy);
                n_state = S_LM_CMP;
            end
            S_LM_CMP: begin
                dsum = 57'(r_dsq) + 57'(prod[55:0]);
                if (dsum < r_best) begin
                    n_best = dsum; n_bdx = r_dx; n_bdy = r_dy; n_linked = 1'b1;
                end
                if (last_k) begin
                    n_state = S_LINK;
                end else begin
                    n_k = r_k + 1'b1;
                    n_state = S_LM_RD;
                end
            end
            S_LINK: begin
                mul_a = MUL_W'(r_bdx); mul_b = MUL_W'(r_bdx);
                if (r_linked) begin
                    n_matched = r_matched + 1'b1;
                    n_state = S_E1;
                end else if (last_i) begin
                    n_state = S_FIN;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_OBS_RD;
                end
            end
            // a linked pair has squared offsets below 2^50, so bits 49:16 carry the high part
            S_E1: begin
                n_ql = prod[15:0];
                mul_a = MUL_W'({1'b0, prod[49:16]}); mul_b = MUL_W'({1'b0, r_ivx});
                n_state = S_E2;
            end
            S_E2: begin
                n_e = prod[59:0];
                mul_a = MUL_W'({1'b0, r_ql}); mul_b = MUL_W'({1'b0, r_ivx});
                n_state = S_E3;
            end
            S_E3: begin
                n_e = r_e + 60'(prod[39:16]);
                mul_a = MUL_W'(r_bdy); mul_b = MUL_W'(r_bdy);
                n_state = S_E4;
            end
            S_E4: begin
                n_ql = prod[15:0];
                mul_a = MUL_W'({1'b0, prod[49:16]}); mul_b = MUL_W'({1'b0, r_ivy});
                n_state = S_E5;
            end
            S_E5: begin
                n_e = r_e + prod[59:0];
                mul_a = MUL_W'({1'b0, r_ql}); mul_b = MUL_W'({1'b0, r_ivy});
                n_state = S_E6;
            end
            S_E6: begin
                esum = r_e + 60'(prod[39:16]);
                n_e = (esum > TERM_CAP) ? TERM_CAP : esum;
                n_state = S_E7;
            end
            S_E7: begin
                mul_a = MUL_W'({1'b0, r_e[40:20]}); mul_b = MUL_W'({1'b0, LOG2E_Q20});
                n_state = S_E8;
            end
            S_E8: begin
                n_acc = prod[59:0];
                mul_a = MUL_W'({1'b0, r_e[19:0]}); mul_b = MUL_W'({1'b0, LOG2E_Q20});
                n_state = S_E9;
            end
            S_E9: begin
                n_total = r_total + 48'(r_norm) - (48'(r_acc) + 48'(prod[40:20]));
                if (last_i) begin
                    n_state = S_FIN;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_OBS_RD;
                end
            end
            S_FIN: begin
                exw = 32'(r_total >>> 16);
                if (exw > 32'sd32767) begin
                    n_exp = 16'sd32767; n_mant = 16'hFFFF;
                    n_state = S_OUT;
                end else if (exw < -32'sd32768) begin
                    n_exp = -16'sd32768; n_mant = 16'h8000;
                    n_state = S_OUT;
                end else begin
                    n_exp = exw[15:0];
                    n_state = S_POW;
                end
            end
            S_POW: begin
                n_mz = {r_total[15:0], 14'b0};
                n_pow = 1'b1;
                n_p = horner_k(1'b1, 3'd5);
                n_hidx = 3'd4;
                n_state = S_HORN_M;
            end
            S_POW_R: begin
                mres = (PROD_W'(1073741824) + PROD_W'(prod >>> 30) + PROD_W'(16384)) >> 15;
                if (mres > PROD_W'(65535))
                    n_mant = 16'hFFFF;
                else if (mres < PROD_W'(32768))
                    n_mant = 16'h8000;
                else
                    n_mant = mres[15:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mark_count <= '0;
            r_seen_count <= '0;
            r_range <= RANGE_RST;
            r_ivx <= IVAR_RST;
            r_ivy <= IVAR_RST;
            r_norm <= NORM_RST;
            r_k <= '0;
            r_i <= '0;
            r_matched <= '0;
        end else begin
            r_state <= n_state;
            r_mark_count <= n_mark_count;
            r_seen_count <= n_seen_count;
            r_k <= n_k;
            r_i <= n_i;
            r_matched <= n_matched;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_RANGE: r_range <= i_cfg_data[22:0];
                    CFG_IVX:   r_ivx <= i_cfg_data;
                    CFG_IVY:   r_ivy <= i_cfg_data;
                    CFG_NORM:  r_norm <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= n_px; r_py <= n_py; r_head <= n_head; r_ptag <= n_ptag;
        r_cos <= n_cos; r_s <= n_s; r_sn <= n_sn; r_cs <= n_cs;
        r_p <= n_p; r_mz <= n_mz; r_hidx <= n_hidx; r_pow <= n_pow;
        r_acc <= n_acc; r_tx <= n_tx; r_ty <= n_ty;
        r_dx <= n_dx; r_dy <= n_dy; r_bdx <= n_bdx; r_bdy <= n_bdy;
        r_dsq <= n_dsq; r_best <= n_best; r_linked <= n_linked;
        r_ql <= n_ql; r_e <= n_e; r_total <= n_total;
        r_mant <= n_mant; r_exp <= n_exp;
    end

    // landmark and observation tables
    always_ff @(posedge i_clk) begin
        if (in_acc && t_kind'(i_kind) == KIND_ADD_MARK
                && r_mark_count < MARK_CW'(MAX_LANDMARKS))
            mark_mem[r_mark_count[MARK_AW-1:0]] <= {i_x_pos, i_y_pos};
        r_mark_q <= mark_mem[r_k[MARK_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && t_kind'(i_kind) == KIND_ADD_OBS && r_seen_count < OBS_CW'(MAX_OBS))
            seen_mem[r_seen_count[OBS_AW-1:0]] <= {i_x_pos, i_y_pos};
        r_seen_q <= seen_mem[r_i[OBS_AW-1:0]];
    end

    assign o_out_particle_tag = r_ptag;
    assign o_weight_mantissa  = r_mant;
    assign o_weight_exponent  = r_exp;
    assign o_matched_count    = r_matched;

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LM_D || r_state == S_LM_CMP) |-> (r_k < r_mark_count))
        else $error("landmark index past table fill");

    a_obs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT0 || r_state == S_LINK) |-> (r_i < r_seen_count))
        else $error("observation index past table fill");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_matched_count <= 5'(r_seen_count)))
        else $error("more matches than observations");

    a_mant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_weight_mantissa[15])
        else $error("mantissa not normalized");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN || r_state == S_POW_R))
        else $error("result raised outside finish");

endmodule

>>> hw/rtl/pwu_mul.sv
module pwu_mul
    import pwu_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule
